// ===== rtl/im2col_pkg.sv =====
`timescale 1ns / 1ps

package im2col_pkg;

   localparam int MAX_DIM_DEFAULT      = 1024;
   localparam int MAX_KERNEL_DEFAULT   = 8;
   localparam int MAX_CHANNELS_DEFAULT = 1024;
   localparam int MAX_BATCH_DEFAULT    = 16;

   localparam int DIM_W      = 11;
   localparam int KERNEL_W   = 4;
   localparam int STEP_W     = 4;
   localparam int PAD_W      = 3;
   localparam int DIL_W      = 4;
   localparam int BATCH_W    = 4;
   localparam int POS_W      = 10;
   localparam int TAP_W      = 3;
   localparam int ADDR_W     = 34;
   localparam int COORD_W    = 17;
   localparam int ROWBASE_W  = BATCH_W + DIM_W;
   localparam int PIX_W      = ROWBASE_W + 1;
   localparam int LIN_W      = 28;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IN_HEIGHT = 3'd0,
      CSR_IN_WIDTH  = 3'd1,
      CSR_CHANNELS  = 3'd2,
      CSR_KERNEL_H  = 3'd3,
      CSR_KERNEL_W  = 3'd4,
      CSR_STRIDE    = 3'd5,
      CSR_PADDING   = 3'd6,
      CSR_DILATION  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]    in_height;
      logic [DIM_W-1:0]    in_width;
      logic [DIM_W-1:0]    channels;
      logic [KERNEL_W-1:0] kernel_h;
      logic [KERNEL_W-1:0] kernel_w;
      logic [STEP_W-1:0]   stride;
      logic [PAD_W-1:0]    padding;
      logic [DIL_W-1:0]    dilation;
   } cfg_type;

   typedef struct packed {
      logic [TAP_W-1:0] row;
      logic [TAP_W-1:0] col;
      logic             last;
   } tap_type;

   typedef struct packed {
      logic    load;
      logic    issue;
      logic    step_row;
      tap_type tap;
   } cmd_type;

   typedef struct packed {
      logic advance;
   } status_type;

endpackage

// ===== rtl/im2col_cfg.sv =====
`timescale 1ns / 1ps

module im2col_cfg #(
   parameter int MAX_DIM      = im2col_pkg::MAX_DIM_DEFAULT,
   parameter int MAX_CHANNELS = im2col_pkg::MAX_CHANNELS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [im2col_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [im2col_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output im2col_pkg::cfg_type                  cfg
);

   localparam int DIM_W = im2col_pkg::DIM_W;

   im2col_pkg::cfg_type regs_ff;
   im2col_pkg::cfg_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_write_enable) begin
         case (im2col_pkg::csr_index_type'(csr_index))
            im2col_pkg::CSR_IN_HEIGHT: regs_in.in_height = csr_write_data;
            im2col_pkg::CSR_IN_WIDTH:  regs_in.in_width  = csr_write_data;
            im2col_pkg::CSR_CHANNELS:  regs_in.channels  = csr_write_data;
            im2col_pkg::CSR_KERNEL_H:  regs_in.kernel_h  = csr_write_data[3:0];
            im2col_pkg::CSR_KERNEL_W:  regs_in.kernel_w  = csr_write_data[3:0];
            im2col_pkg::CSR_STRIDE:    regs_in.stride    = csr_write_data[3:0];
            im2col_pkg::CSR_PADDING:   regs_in.padding   = csr_write_data[2:0];
            im2col_pkg::CSR_DILATION:  regs_in.dilation  = csr_write_data[3:0];
            default:                   regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.in_height <= DIM_W'(1);
         regs_ff.in_width  <= DIM_W'(1);
         regs_ff.channels  <= DIM_W'(1);
         regs_ff.kernel_h  <= 4'd1;
         regs_ff.kernel_w  <= 4'd1;
         regs_ff.stride    <= 4'd1;
         regs_ff.padding   <= 3'd0;
         regs_ff.dilation  <= 4'd1;
      end else begin
         regs_ff <= regs_in;
      end
   end

   // dimensions saturate at the configured maxima
   always_comb begin
      cfg = regs_ff;
      if (32'(regs_ff.in_height) > MAX_DIM) cfg.in_height = DIM_W'(MAX_DIM);
      if (32'(regs_ff.in_width) > MAX_DIM)  cfg.in_width  = DIM_W'(MAX_DIM);
      if (32'(regs_ff.channels) > MAX_CHANNELS) cfg.channels = DIM_W'(MAX_CHANNELS);
   end

endmodule

// ===== rtl/im2col_ctrl.sv =====
`timescale 1ns / 1ps

module im2col_ctrl #(
   parameter int MAX_KERNEL = im2col_pkg::MAX_KERNEL_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  im2col_pkg::cfg_type    cfg,
   input  im2col_pkg::status_type status,
   input  logic                   req_valid,
   output logic                   req_ready,
   output im2col_pkg::cmd_type    cmd
);

   localparam int CW    = $clog2(MAX_KERNEL + 1);
   localparam int TAP_W = im2col_pkg::TAP_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [CW-1:0]   kh_n, kw_n;
   logic            col_end, row_end, last, issue, accept;

   always_comb begin
      if (cfg.kernel_h == 4'd0)            kh_n = CW'(1);
      else if (32'(cfg.kernel_h) > MAX_KERNEL) kh_n = CW'(MAX_KERNEL);
      else                                 kh_n = CW'(cfg.kernel_h);
      if (cfg.kernel_w == 4'd0)            kw_n = CW'(1);
      else if (32'(cfg.kernel_w) > MAX_KERNEL) kw_n = CW'(MAX_KERNEL);
      else                                 kw_n = CW'(cfg.kernel_w);
   end

   assign col_end   = (col_ff == kw_n - CW'(1));
   assign row_end   = (row_ff == kh_n - CW'(1));
   assign last      = col_end && row_end;
   assign issue     = (state_ff == ST_RUN) && status.advance;
   assign req_ready = (state_ff == ST_IDLE) || (issue && last);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               row_in   = '0;
               col_in   = '0;
            end
         end
         ST_RUN: begin
            if (accept) begin
               row_in = '0;
               col_in = '0;
            end else if (issue && last) begin
               state_in = ST_IDLE;
            end else if (issue && col_end) begin
               row_in = row_ff + CW'(1);
               col_in = '0;
            end else if (issue) begin
               col_in = col_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

   always_comb begin
      cmd.load     = accept;
      cmd.issue    = issue;
      cmd.step_row = issue && col_end;
      cmd.tap.row  = TAP_W'(row_ff);
      cmd.tap.col  = TAP_W'(col_ff);
      cmd.tap.last = last;
   end

endmodule

// ===== rtl/im2col_dp.sv =====
`timescale 1ns / 1ps

module im2col_dp #(
   parameter int MAX_BATCH = im2col_pkg::MAX_BATCH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  im2col_pkg::cfg_type                 cfg,
   input  im2col_pkg::cmd_type                 cmd,
   output im2col_pkg::status_type              status,
   input  logic [im2col_pkg::BATCH_W-1:0]      req_batch_index,
   input  logic [im2col_pkg::POS_W-1:0]        req_out_row,
   input  logic [im2col_pkg::POS_W-1:0]        req_out_col,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [im2col_pkg::TAP_W-1:0]        rsp_tap_row,
   output logic [im2col_pkg::TAP_W-1:0]        rsp_tap_col,
   output logic [im2col_pkg::ADDR_W-1:0]       rsp_src_address,
   output logic                                rsp_zero_fill,
   output logic                                rsp_last_tap
);

   localparam int BATCH_W   = im2col_pkg::BATCH_W;
   localparam int DIM_W     = im2col_pkg::DIM_W;
   localparam int POS_W     = im2col_pkg::POS_W;
   localparam int COORD_W   = im2col_pkg::COORD_W;
   localparam int ROWBASE_W = im2col_pkg::ROWBASE_W;
   localparam int PIX_W     = im2col_pkg::PIX_W;
   localparam int LIN_W     = im2col_pkg::LIN_W;
   localparam int ADDR_W    = im2col_pkg::ADDR_W;
   localparam int PROD_W    = POS_W + im2col_pkg::STEP_W;
   localparam int FULL_W    = LIN_W + DIM_W;

   logic advance;

   // per-word setup
   logic [BATCH_W-1:0]          batch_c;
   logic [ROWBASE_W-1:0]        row_base_in;
   logic [PROD_W-1:0]           prod_h, prod_w;
   logic signed [COORD_W-1:0]   base_h_in, base_w_in, dil;

   logic [ROWBASE_W-1:0]        row_base_ff;
   logic signed [COORD_W-1:0]   base_w_ff;
   logic signed [COORD_W-1:0]   cur_h_ff, cur_h_in;
   logic signed [COORD_W-1:0]   cur_w_ff, cur_w_in;

   // tap pipeline
   logic                        s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   im2col_pkg::tap_type         s1_tap_ff, s2_tap_ff, s3_tap_ff;
   logic signed [COORD_W-1:0]   s1_h_ff, s1_w_ff;
   logic [ROWBASE_W-1:0]        s1_row_base_ff;
   logic                        s1_inside;
   logic [PIX_W-1:0]            s1_pix;
   logic                        s2_inside_ff;
   logic [PIX_W-1:0]            s2_pix_ff;
   logic [DIM_W-1:0]            s2_w_ff;
   logic [LIN_W-1:0]            s2_lin;
   logic                        s3_inside_ff;
   logic [LIN_W-1:0]            s3_lin_ff;
   logic [FULL_W-1:0]           s3_full;
   im2col_pkg::tap_type         out_tap_ff;
   logic [ADDR_W-1:0]           out_addr_ff;
   logic                        out_zero_ff;

   assign advance        = !out_valid_ff || rsp_ready;
   assign status.advance = advance;

   always_comb begin
      if (32'(req_batch_index) > MAX_BATCH - 1) batch_c = BATCH_W'(MAX_BATCH - 1);
      else                                      batch_c = req_batch_index;
      row_base_in = {{DIM_W{1'b0}}, batch_c} * {{BATCH_W{1'b0}}, cfg.in_height};
      prod_h    = {4'd0, req_out_row} * {{POS_W{1'b0}}, cfg.stride};
      prod_w    = {4'd0, req_out_col} * {{POS_W{1'b0}}, cfg.stride};
      base_h_in = $signed({3'b000, prod_h}) - $signed({14'd0, cfg.padding});
      base_w_in = $signed({3'b000, prod_w}) - $signed({14'd0, cfg.padding});
      dil       = $signed({13'd0, cfg.dilation});
   end

   always_comb begin
      cur_h_in = cur_h_ff;
      cur_w_in = cur_w_ff;
      if (cmd.load) begin
         cur_h_in = base_h_in;
         cur_w_in = base_w_in;
      end else if (cmd.step_row) begin
         cur_h_in = cur_h_ff + dil;
         cur_w_in = base_w_ff;
      end else if (cmd.issue) begin
         cur_w_in = cur_w_ff + dil;
      end
   end

   always_ff @(posedge clock) begin
      cur_h_ff <= cur_h_in;
      cur_w_ff <= cur_w_in;
      if (cmd.load) begin
         base_w_ff   <= base_w_in;
         row_base_ff <= row_base_in;
      end
   end

   always_comb begin
      s1_inside = !s1_h_ff[COORD_W-1] && !s1_w_ff[COORD_W-1]
                  && (s1_h_ff < $signed({6'd0, cfg.in_height}))
                  && (s1_w_ff < $signed({6'd0, cfg.in_width}));
      s1_pix  = {1'b0, s1_row_base_ff} + {5'd0, s1_h_ff[DIM_W-1:0]};
      s2_lin  = {{(LIN_W-PIX_W){1'b0}}, s2_pix_ff} * {{(LIN_W-DIM_W){1'b0}}, cfg.in_width}
                + {{(LIN_W-DIM_W){1'b0}}, s2_w_ff};
      s3_full = {{DIM_W{1'b0}}, s3_lin_ff} * {{LIN_W{1'b0}}, cfg.channels};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tap_ff      <= cmd.tap;
         s1_h_ff        <= cur_h_ff;
         s1_w_ff        <= cur_w_ff;
         s1_row_base_ff <= row_base_ff;
         s2_tap_ff      <= s1_tap_ff;
         s2_inside_ff   <= s1_inside;
         s2_pix_ff      <= s1_pix;
         s2_w_ff        <= s1_w_ff[DIM_W-1:0];
         s3_tap_ff      <= s2_tap_ff;
         s3_inside_ff   <= s2_inside_ff;
         s3_lin_ff      <= s2_lin;
         out_tap_ff     <= s3_tap_ff;
         out_zero_ff    <= !s3_inside_ff;
         out_addr_ff    <= s3_inside_ff ? s3_full[ADDR_W-1:0] : '0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_tap_row     = out_tap_ff.row;
   assign rsp_tap_col     = out_tap_ff.col;
   assign rsp_last_tap    = out_tap_ff.last;
   assign rsp_src_address = out_addr_ff;
   assign rsp_zero_fill   = out_zero_ff;

endmodule

// ===== rtl/im2col_nhwc_address_gen_unit.sv =====
`timescale 1ns / 1ps

// channel  direction  handshake                    payload
// req      in         req_valid / req_ready        batch_index, out_row, out_col
// rsp      out        rsp_valid / rsp_ready        tap_row, tap_col, src_address,
//                                                  zero_fill, last_tap
// csr      in         csr_write_enable             csr_index, csr_write_data
//
// One tap word per cycle while rsp does not stall: a word yields kernel_h * kernel_w
// taps, set by the tap sequencer; the next word is taken on the cycle of the final tap.
// A tap passes the coordinate regs, three address stages and the output reg.
// Reset is synchronous; config registers come up at 1, padding at 0.
// A stall on rsp freezes the whole tap pipeline and the sequencer once it is running.

module im2col_nhwc_address_gen_unit #(
   parameter int MAX_DIM      = im2col_pkg::MAX_DIM_DEFAULT,
   parameter int MAX_KERNEL   = im2col_pkg::MAX_KERNEL_DEFAULT,
   parameter int MAX_CHANNELS = im2col_pkg::MAX_CHANNELS_DEFAULT,
   parameter int MAX_BATCH    = im2col_pkg::MAX_BATCH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [im2col_pkg::BATCH_W-1:0]      req_batch_index,
   input  logic [im2col_pkg::POS_W-1:0]        req_out_row,
   input  logic [im2col_pkg::POS_W-1:0]        req_out_col,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [im2col_pkg::TAP_W-1:0]        rsp_tap_row,
   output logic [im2col_pkg::TAP_W-1:0]        rsp_tap_col,
   output logic [im2col_pkg::ADDR_W-1:0]       rsp_src_address,
   output logic                                rsp_zero_fill,
   output logic                                rsp_last_tap,
   input  logic                                csr_write_enable,
   input  logic [im2col_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [im2col_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   im2col_pkg::cfg_type    cfg;
   im2col_pkg::cmd_type    cmd;
   im2col_pkg::status_type status;

   im2col_cfg #(
      .MAX_DIM      (MAX_DIM),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   im2col_ctrl #(
      .MAX_KERNEL (MAX_KERNEL)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .status    (status),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   im2col_dp #(
      .MAX_BATCH (MAX_BATCH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_batch_index (req_batch_index),
      .req_out_row     (req_out_row),
      .req_out_col     (req_out_col),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tap_row     (rsp_tap_row),
      .rsp_tap_col     (rsp_tap_col),
      .rsp_src_address (rsp_src_address),
      .rsp_zero_fill   (rsp_zero_fill),
      .rsp_last_tap    (rsp_last_tap)
   );

endmodule
